// ===== hw/rtl/line_follower_pd_drive_core_defines.svh =====
// ----------------------------------------------------------------------------
// Line follower PD drive core: assertion macros
// Shared assertion forms for the drive core. Each macro samples on clk and is
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef LINE_FOLLOWER_PD_DRIVE_CORE_DEFINES_SVH
`define LINE_FOLLOWER_PD_DRIVE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LFPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LFPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lfpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Line follower PD drive package
// Types, register codes, reset values and small helper functions shared by
// the drive core.
// ----------------------------------------------------------------------------
`default_nettype none

package lfpd_pkg;

  // Signed line error, as reported on the result port.
  typedef logic signed [6:0] err_t;
  // Signed weighted sensor sum, at most 150 in magnitude.
  typedef logic signed [8:0] sum_t;
  // Signed PD correction, at most about 5900 in magnitude.
  typedef logic signed [13:0] corr_t;
  // Signed motor drive value before the divide by four.
  typedef logic signed [14:0] drive_t;

  // Motor direction codes.
  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_SENSOR_WEIGHT  = 3'd0,
    CFG_GAIN_P         = 3'd1,
    CFG_GAIN_D         = 3'd2,
    CFG_BASE_POWER     = 3'd3,
    CFG_LOST_THRESHOLD = 3'd4,
    CFG_LOST_ERROR     = 3'd5
  } cfg_idx_t;

  // Turn request bits.
  localparam logic [1:0] TURN_NONE  = 2'd0;
  localparam logic [1:0] TURN_LEFT  = 2'd1;
  localparam logic [1:0] TURN_RIGHT = 2'd2;

  // Register reset values.
  localparam logic [3:0] SENSOR_WEIGHT_RST  = 4'd9;
  localparam logic [4:0] GAIN_P_RST         = 5'd9;
  localparam logic [4:0] GAIN_D_RST         = 5'd3;
  localparam logic [9:0] BASE_POWER_RST     = 10'd400;
  localparam logic [5:0] LOST_THRESHOLD_RST = 6'd35;
  localparam logic [5:0] LOST_ERROR_RST     = 6'd40;

  // Saturated motor duty limit.
  localparam logic [7:0] DUTY_MAX = 8'd255;

  // One motor command.
  typedef struct packed {
    dir_t       dir;
    logic [7:0] duty;
  } motor_t;

  // Magnitude of the position weight of a sensor: 4,3,2,1 on the left half
  // and 1,2,3,4 on the right half.
  function automatic logic [2:0] pos_weight_mag(input logic [2:0] idx);
    logic [2:0] mag;
    if (idx[2]) begin
      mag = idx - 3'd3;
    end else begin
      mag = 3'd4 - idx;
    end
    return mag;
  endfunction

  // Split a drive value into direction and a duty of |v|/4, saturated.
  function automatic motor_t motor_drive(input drive_t v);
    logic [14:0] uv;
    logic [14:0] mag;
    logic [12:0] q;
    motor_t      m;
    uv  = v;
    mag = v[14] ? (~uv + 15'd1) : uv;
    q   = mag[14:2];
    if (q == 13'd0) begin
      m.dir = DIR_STOP;
    end else if (v[14]) begin
      m.dir = DIR_REV;
    end else begin
      m.dir = DIR_FWD;
    end
    m.duty = (q > 13'(DUTY_MAX)) ? DUTY_MAX : q[7:0];
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/line_follower_pd_drive_core.sv =====
// ----------------------------------------------------------------------------
// Line follower PD drive core
// Turns one eight-bit line sensor sample into a line error, a sharp-turn
// report and two motor commands through a PD control law.
// ----------------------------------------------------------------------------
// One sample is worked on at a time. The sequencer walks the eight sensors one
// per cycle through a single weight accumulator, then runs a bit-serial
// restoring divider over the eight quotient bits, then uses one shared multiplier
// twice for the P and D terms. A sample with no active sensor skips the
// divider. If the previous result has not yet been taken the final drive
// step waits for the output register to free up. The result register lets
// the next sample enter while a finished result is still held.
// Configuration writes are always taken and should only be issued while idle.
`default_nettype none

`include "line_follower_pd_drive_core_defines.svh"

module line_follower_pd_drive_core (
  input  logic                clk,
  input  logic                rst,
  // Sample input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          sensor_bits,
  // Result channel
  output logic                out_valid,
  input  logic                out_stall,
  output lfpd_pkg::err_t      line_error,
  output logic [1:0]          turn_request,
  output logic [1:0]          left_direction,
  output logic [7:0]          left_duty,
  output logic [1:0]          right_direction,
  output logic [7:0]          right_duty,
  // Configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [9:0]          cfg_data
);

  import lfpd_pkg::*;

  // Sequencer states.
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_ACCUM = 8'b0000_0010,
    S_PREP  = 8'b0000_0100,
    S_DIV   = 8'b0000_1000,
    S_SIGN  = 8'b0001_0000,
    S_MUL_P = 8'b0010_0000,
    S_MUL_D = 8'b0100_0000,
    S_DRIVE = 8'b1000_0000
  } state_t;

  state_t      state;
  state_t      state_next;

  // Configuration registers.
  logic [3:0]  sensor_weight;
  logic [4:0]  gain_p;
  logic [4:0]  gain_d;
  logic [9:0]  base_power;
  logic [5:0]  lost_threshold;
  logic [5:0]  lost_error;

  // Controller state carried between items.
  err_t        last_position;
  err_t        previous_error;

  // Working registers of the current item.
  logic [7:0]  sens;
  logic [1:0]  turn;
  logic [2:0]  idx;
  sum_t        sum;
  logic [3:0]  cnt;
  logic        neg;
  logic [7:0]  quo;
  logic [3:0]  rem;
  err_t        err;
  corr_t       corr;

  logic        in_take;
  logic        out_take;
  logic        out_load;
  logic        cfg_take;
  logic [1:0]  turn_now;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign cfg_take = cfg_valid && cfg_ready;
  assign in_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load = (state == S_DRIVE) && !(out_valid && out_stall);

  // Sharp-turn patterns on the incoming sample.
  always_comb begin
    turn_now = TURN_NONE;
    if (sensor_bits[0] && sensor_bits[2]) begin
      turn_now = turn_now | TURN_LEFT;
    end
    if (sensor_bits[7] && sensor_bits[5]) begin
      turn_now = turn_now | TURN_RIGHT;
    end
  end

  // Weight accumulator: one sensor per cycle.
  logic [6:0]  term_mag;
  sum_t        term;
  sum_t        sum_next;
  logic [3:0]  cnt_next;

  always_comb begin
    term_mag = 7'({4'b0, pos_weight_mag(idx)} * {3'b0, sensor_weight});
    term     = idx[2] ? sum_t'({2'b0, term_mag}) : -sum_t'({2'b0, term_mag});
    sum_next = sum;
    cnt_next = cnt;
    if (sens[idx]) begin
      sum_next = sum + term;
      cnt_next = cnt + 4'd1;
    end
  end

  // Divider setup and lost-line error.
  logic [8:0]  sum_u;
  logic [7:0]  sum_abs;
  logic signed [7:0] lp_ext;
  logic signed [7:0] thr_ext;
  err_t        lost_val;

  always_comb begin
    sum_u   = sum;
    sum_abs = sum[8] ? 8'(~sum_u + 9'd1) : sum_u[7:0];
    lp_ext  = 8'(last_position);
    thr_ext = $signed({2'b0, lost_threshold});
    if (lp_ext < -thr_ext) begin
      lost_val = -err_t'({1'b0, lost_error});
    end else if (lp_ext > thr_ext) begin
      lost_val = err_t'({1'b0, lost_error});
    end else begin
      lost_val = '0;
    end
  end

  // Restoring divider step: one quotient bit per cycle.
  logic [4:0]  trial;
  logic        fits;
  logic [3:0]  rem_next;
  logic [7:0]  quo_next;
  err_t        quo_signed;

  always_comb begin
    trial      = {rem, quo[7]};
    fits       = (trial >= {1'b0, cnt});
    rem_next   = fits ? 4'(trial - {1'b0, cnt}) : trial[3:0];
    quo_next   = {quo[6:0], fits};
    quo_signed = neg ? -err_t'(quo[6:0]) : err_t'(quo[6:0]);
  end

  // Shared multiplier for the P and D terms.
  logic [4:0]  mul_a;
  logic signed [7:0] mul_b;
  corr_t       product;

  always_comb begin
    if (state == S_MUL_D) begin
      mul_a = gain_d;
      mul_b = 8'(err) - 8'(previous_error);
    end else begin
      mul_a = gain_p;
      mul_b = 8'(err);
    end
    product = $signed({1'b0, mul_a}) * mul_b;
  end

  // Motor values.
  drive_t      base_ext;
  drive_t      corr_ext;
  motor_t      left_cmd;
  motor_t      right_cmd;

  always_comb begin
    base_ext  = $signed({5'b0, base_power});
    corr_ext  = drive_t'(corr);
    left_cmd  = motor_drive(base_ext + corr_ext);
    right_cmd = motor_drive(base_ext - corr_ext);
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          state_next = S_ACCUM;
        end
      end
      S_ACCUM: begin
        if (idx == 3'd7) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        state_next = (cnt == 4'd0) ? S_MUL_P : S_DIV;
      end
      S_DIV: begin
        if (idx == 3'd7) begin
          state_next = S_SIGN;
        end
      end
      S_SIGN: begin
        state_next = S_MUL_P;
      end
      S_MUL_P: begin
        state_next = S_MUL_D;
      end
      S_MUL_D: begin
        state_next = S_DRIVE;
      end
      S_DRIVE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state, configuration and carried controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      sensor_weight  <= SENSOR_WEIGHT_RST;
      gain_p         <= GAIN_P_RST;
      gain_d         <= GAIN_D_RST;
      base_power     <= BASE_POWER_RST;
      lost_threshold <= LOST_THRESHOLD_RST;
      lost_error     <= LOST_ERROR_RST;
      last_position  <= '0;
      previous_error <= '0;
    end else begin
      state <= state_next;

      // Result register handshake.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end

      // Register writes; unknown indexes are dropped.
      if (cfg_take) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SENSOR_WEIGHT:  sensor_weight  <= cfg_data[3:0];
          CFG_GAIN_P:         gain_p         <= cfg_data[4:0];
          CFG_GAIN_D:         gain_d         <= cfg_data[4:0];
          CFG_BASE_POWER:     base_power     <= cfg_data[9:0];
          CFG_LOST_THRESHOLD: lost_threshold <= cfg_data[5:0];
          CFG_LOST_ERROR:     lost_error     <= cfg_data[5:0];
          default: begin
          end
        endcase
      end

      // A sharp turn resets the controller memory.
      if (in_take && (turn_now != TURN_NONE)) begin
        last_position  <= '0;
        previous_error <= '0;
      end else if (state == S_SIGN) begin
        last_position <= quo_signed;
      end else if (state == S_MUL_D) begin
        previous_error <= err;
      end
    end
  end

  // Datapath registers of the current item and the result register.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          sens <= sensor_bits;
          turn <= turn_now;
          idx  <= '0;
          sum  <= '0;
          cnt  <= '0;
        end
      end
      S_ACCUM: begin
        sum <= sum_next;
        cnt <= cnt_next;
        idx <= idx + 3'd1;
      end
      S_PREP: begin
        neg <= sum[8];
        quo <= sum_abs;
        rem <= '0;
        idx <= '0;
        err <= lost_val;
      end
      S_DIV: begin
        quo <= quo_next;
        rem <= rem_next;
        idx <= idx + 3'd1;
      end
      S_SIGN: begin
        err <= quo_signed;
      end
      S_MUL_P: begin
        corr <= product;
      end
      S_MUL_D: begin
        corr <= corr + product;
      end
      S_DRIVE: begin
        if (out_load) begin
          line_error      <= err;
          turn_request    <= turn;
          left_direction  <= left_cmd.dir;
          left_duty       <= left_cmd.duty;
          right_direction <= right_cmd.dir;
          right_duty      <= right_cmd.duty;
        end
      end
      default: begin
      end
    endcase
  end

  // Checks on the sequencer and datapath.
  `LFPD_ASSERT_NEXT(a_take_starts_accum, in_take, state == S_ACCUM, "accepted item did not start accumulation")
  `LFPD_ASSERT_NOW(a_div_rem_bound, state == S_DIV, rem < cnt, "divider remainder reached the divisor")
  `LFPD_ASSERT_NOW(a_err_in_range, state == S_MUL_P, err != -7'sd64, "line error left its range")
  `LFPD_ASSERT_NOW(a_result_from_drive, $rose(out_valid), $past(state) == S_DRIVE, "result appeared outside the drive step")

endmodule

`default_nettype wire
